// File: hw/rtl/mrpu_pkg.sv
`timescale 1ns / 1ps

package mrpu_pkg;

  // Packing formats of the raw stream.
  typedef enum logic [1:0] {
    DtRaw8  = 2'd0,
    DtRaw10 = 2'd1,
    DtRaw12 = 2'd2,
    DtRaw16 = 2'd3
  } data_type_e;

  // Configuration register indexes. Index 3 is not a register and is ignored.
  typedef enum logic [1:0] {
    RegDataType    = 2'd0,
    RegFrameWidth  = 2'd1,
    RegFrameHeight = 2'd2
  } cfg_reg_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PixelW  = 16;
  localparam int unsigned DimRegW = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GroupPix = 4;
  localparam int unsigned PhaseW  = 3;

  localparam logic [1:0] Raw10LsbMask = 2'h3;
  localparam logic [3:0] Raw12LsbMask = 4'hf;

  localparam logic [DimRegW-1:0] ResetWidth  = 14'd1920;
  localparam logic [DimRegW-1:0] ResetHeight = 14'd1080;

  // Phase of the last byte of a packing group, one less than the group length in bytes.
  function automatic logic [PhaseW-1:0] last_phase(data_type_e dt);
    logic [PhaseW-1:0] r;
    unique case (dt)
      DtRaw8:  r = 3'd0;
      DtRaw10: r = 3'd4;
      DtRaw12: r = 3'd2;
      DtRaw16: r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/mipi_raw_pixel_unpacker.sv
`timescale 1ns / 1ps

// Unpacks a MIPI CSI-2 RAW8/RAW10/RAW12/RAW16 byte stream into 16-bit pixels, right aligned.
// One byte is taken per cycle while s_axis_tready is high. The byte that completes a packing
// group loads all of its pixels (up to four for RAW10) into a group buffer, which drains one
// pixel per cycle into the output register while the output is free. Bytes that only fill a
// group are always taken; a completing byte waits only while the previous group is still
// draining, which happens only under output backpressure or after a data type write, so
// without backpressure the sustained rate is one byte per cycle in every format. tlast marks
// the final pixel of a frame (width times height pixels, each dimension clamped to
// 1..MAX_DIM); pixels of a group beyond that point are dropped and counting restarts. tuser
// flags the last pixel that one input byte produced. Writing the data type restarts group
// collection. After a dimension write the frame total is recomputed and registered.
module mipi_raw_pixel_unpacker #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mrpu_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mrpu_pkg::DimRegW-1:0]     cfg_data_i,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mrpu_pkg::ByteW-1:0]       s_axis_tdata,   // [7:0] byte_in

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mrpu_pkg::PixelW-1:0]      m_axis_tdata,   // [15:0] pixel
  output logic                             m_axis_tlast,   // frame_end
  output logic                             m_axis_tuser    // [0] group_end
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW = (DimW > mrpu_pkg::DimRegW) ? DimW : mrpu_pkg::DimRegW;
  localparam int unsigned TotW = 2 * DimW;
  localparam logic [CmpW-1:0] MaxDimC = CmpW'(MAX_DIM);

  // Configuration registers.
  mrpu_pkg::data_type_e             data_type_q;
  logic [mrpu_pkg::DimRegW-1:0]     width_q, height_q;
  logic [TotW-1:0]                  total_q, total_d;

  // Group collection.
  logic [mrpu_pkg::ByteW-1:0]       hold_q [mrpu_pkg::GroupPix];
  logic [mrpu_pkg::PhaseW-1:0]      phase_q, phase_d, phase_eff, glast;
  logic                             completes;

  // Group buffer.
  logic [mrpu_pkg::PixelW-1:0]      px_q [mrpu_pkg::GroupPix];
  logic [mrpu_pkg::PixelW-1:0]      px_d [mrpu_pkg::GroupPix];
  logic                             buf_valid_q, buf_valid_d;
  logic [1:0]                       idx_q, idx_d, lastidx_q, lastidx_d;
  logic [TotW-1:0]                  pix_cnt_q, pix_cnt_d;

  // Output register.
  logic                             out_valid_q, out_valid_d;
  logic [mrpu_pkg::PixelW-1:0]      out_pix_q, out_pix_d;
  logic                             out_fend_q, out_fend_d, out_gend_q, out_gend_d;

  logic                             out_free, drain, fend, gdone, load, byte_acc, cfg_wr;
  logic [mrpu_pkg::ByteW-1:0]       b;

  function automatic logic [DimW-1:0] clamp_dim(logic [mrpu_pkg::DimRegW-1:0] v);
    logic [CmpW-1:0] e;
    logic [DimW-1:0] r;
    e = CmpW'(v);
    if (e == '0) begin
      r = DimW'(1);
    end else if (e > MaxDimC) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = DimW'(e);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign b           = s_axis_tdata;

  assign total_d = TotW'(clamp_dim(width_q)) * TotW'(clamp_dim(height_q));

  assign glast     = mrpu_pkg::last_phase(data_type_q);
  assign phase_eff = (phase_q > glast) ? '0 : phase_q;
  assign completes = (phase_eff == glast);

  assign out_free = !out_valid_q || m_axis_tready;
  assign drain    = buf_valid_q && out_free;
  assign fend     = ({1'b0, pix_cnt_q} + (TotW + 1)'(1)) >= {1'b0, total_q};
  assign gdone    = fend || (idx_q == lastidx_q);

  assign s_axis_tready = !completes || !buf_valid_q || (drain && gdone);
  assign byte_acc      = s_axis_tvalid && s_axis_tready;
  assign load          = byte_acc && completes;

  always_comb begin
    phase_d = phase_q;
    if (byte_acc) begin
      phase_d = completes ? '0 : phase_eff + 3'd1;
    end
    if (cfg_wr && (cfg_index_i == mrpu_pkg::RegDataType)) begin
      phase_d = '0;
    end
  end

  // Unpack the completed group.
  always_comb begin
    for (int k = 0; k < mrpu_pkg::GroupPix; k++) begin
      px_d[k] = '0;
    end
    lastidx_d = 2'd0;
    unique case (data_type_q)
      mrpu_pkg::DtRaw8: begin
        px_d[0] = {8'd0, b};
      end
      mrpu_pkg::DtRaw10: begin
        for (int k = 0; k < mrpu_pkg::GroupPix; k++) begin
          px_d[k] = {6'd0, hold_q[k], b[7 - 2 * k -: 2] & mrpu_pkg::Raw10LsbMask};
        end
        lastidx_d = 2'd3;
      end
      mrpu_pkg::DtRaw12: begin
        px_d[0] = {4'd0, hold_q[0], b[7:4] & mrpu_pkg::Raw12LsbMask};
        px_d[1] = {4'd0, hold_q[1], b[3:0] & mrpu_pkg::Raw12LsbMask};
        lastidx_d = 2'd1;
      end
      mrpu_pkg::DtRaw16: begin
        px_d[0] = {b, hold_q[0]};
      end
      default: begin
        px_d[0] = {8'd0, b};
      end
    endcase
  end

  always_comb begin
    buf_valid_d = buf_valid_q;
    idx_d       = idx_q;
    pix_cnt_d   = pix_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pix_d   = out_pix_q;
    out_fend_d  = out_fend_q;
    out_gend_d  = out_gend_q;
    if (drain) begin
      out_valid_d = 1'b1;
      out_pix_d   = px_q[idx_q];
      out_fend_d  = fend;
      out_gend_d  = gdone;
      pix_cnt_d   = fend ? '0 : pix_cnt_q + TotW'(1);
      idx_d       = idx_q + 2'd1;
      if (gdone) begin
        buf_valid_d = 1'b0;
      end
    end
    if (load) begin
      buf_valid_d = 1'b1;
      idx_d       = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= mrpu_pkg::DtRaw10;
      width_q     <= mrpu_pkg::ResetWidth;
      height_q    <= mrpu_pkg::ResetHeight;
      total_q     <= '0;
      phase_q     <= '0;
      buf_valid_q <= 1'b0;
      idx_q       <= '0;
      lastidx_q   <= '0;
      pix_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < mrpu_pkg::GroupPix; k++) begin
        hold_q[k] <= '0;
      end
    end else begin
      total_q     <= total_d;
      phase_q     <= phase_d;
      buf_valid_q <= buf_valid_d;
      idx_q       <= idx_d;
      pix_cnt_q   <= pix_cnt_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        lastidx_q <= lastidx_d;
      end
      if (byte_acc && !completes) begin
        hold_q[phase_eff[1:0]] <= b;
      end
      if (cfg_wr) begin
        unique case (cfg_index_i)
          mrpu_pkg::RegDataType:    data_type_q <= mrpu_pkg::data_type_e'(cfg_data_i[1:0]);
          mrpu_pkg::RegFrameWidth:  width_q     <= cfg_data_i;
          mrpu_pkg::RegFrameHeight: height_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < mrpu_pkg::GroupPix; k++) begin
        px_q[k] <= px_d[k];
      end
    end
    out_pix_q  <= out_pix_d;
    out_fend_q <= out_fend_d;
    out_gend_q <= out_gend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_fend_q;
  assign m_axis_tuser  = out_gend_q;

`ifndef SYNTH
  // A new group never overwrites one that still has pixels to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!buf_valid_q || (drain && gdone)))
    else $error("group buffer overrun");

  // The frame-end pixel always closes its group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("frame end without group end");

  // The collection phase stays inside the current group length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= glast)
    else $error("byte phase out of range");

  // The drain index never passes the last pixel of the group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (idx_q <= lastidx_q))
    else $error("group drain index out of range");
`endif

endmodule
